// ----- hdl/brtu_pkg.sv -----
// ----------------------------------------------------------------------------
// brtu_pkg: shared definitions of the trace upsampler
// widths, register indexes, sequencer states and the hand-over record
// ----------------------------------------------------------------------------
package brtu_pkg;

  // points emitted per sample
  localparam int unsigned POINTS_PER_SAMPLE = 40;
  localparam int unsigned CNT_W = $clog2(POINTS_PER_SAMPLE);
  localparam int unsigned REM_W = $clog2(POINTS_PER_SAMPLE);

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned BASE_W   = 16;
  localparam int unsigned GAIN_W   = 7;
  localparam int unsigned SHIFT_W  = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEVIATION_GAIN = 1'b0,
    CFG_AVERAGE_SHIFT  = 1'b1
  } cfg_idx_e;

  localparam logic [GAIN_W-1:0]   GAIN_RESET  = GAIN_W'(16);
  localparam logic [SHIFT_W-1:0]  SHIFT_RESET = SHIFT_W'(4);
  localparam logic [SAMPLE_W-1:0] CENTRE      = SAMPLE_W'(128);
  localparam logic [SAMPLE_W-1:0] SAT_MAX     = SAMPLE_W'(255);

  typedef enum logic [1:0] {
    TGT_IDLE,
    TGT_BASE,
    TGT_GAIN
  } tgt_state_e;

  typedef enum logic [1:0] {
    RAMP_IDLE,
    RAMP_DIV,
    RAMP_EMIT
  } ramp_state_e;

  // new target handed from the target stage to the ramp engine
  typedef struct packed {
    logic                valid;
    logic                first;
    logic [SAMPLE_W-1:0] target;
  } tgt_req_t;

endpackage

// ----- hdl/brtu_if.sv -----
// ----------------------------------------------------------------------------
// brtu_if: request channels of the trace upsampler
// sample channel in, trace point channel out, valid/ready handshake
// ----------------------------------------------------------------------------
interface brtu_in_if;
  logic                          valid;
  logic                          ready;
  logic [brtu_pkg::SAMPLE_W-1:0] noise_sample;

  modport source (output valid, output noise_sample, input ready);
  modport sink   (input valid, input noise_sample, output ready);
endinterface

interface brtu_out_if;
  logic                          valid;
  logic                          ready;
  logic [brtu_pkg::SAMPLE_W-1:0] trace_value;
  logic                          last_point;

  modport source (output valid, output trace_value, output last_point, input ready);
  modport sink   (input valid, input trace_value, input last_point, output ready);
endinterface

// ----- hdl/baseline_removed_trace_upsampler_unit.sv -----
// ----------------------------------------------------------------------------
// baseline_removed_trace_upsampler_unit: baseline removal and trace upsampling
// turns each noise sample into a ramp of display points around a tracked mean
// ----------------------------------------------------------------------------
// Each accepted noise sample updates an 8.8 fixed point moving average (the
// first sample after reset seeds it), multiplies the deviation of the sample
// from the integer baseline by deviation_gain, centres it at 128 and clips it
// to 0..255. The unit then sends 40 points that ramp linearly, truncating
// toward zero, from the previous target to the new one; the 40th point equals
// the target and carries last_point. Each sample passes in order through the
// target steps (baseline update, gain multiply and hand-over to the ramp
// engine), a short middle phase in which the shared compare/subtract unit
// splits the step, the distance between old and new target, into a
// per-point quotient and remainder, and the point phase, which reuses that
// unit to accumulate the ramp, one point per cycle into the output register
// whenever that register is empty or its point is being taken. The sample
// channel is ready again as soon as the final point has been loaded, even if
// it still waits to be taken. Output back-pressure only stretches the point
// phase. Configuration writes are meant for idle periods.
// ----------------------------------------------------------------------------
module baseline_removed_trace_upsampler_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [brtu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [brtu_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  brtu_in_if.sink                          sample_i,
  brtu_out_if.source                       trace_o
);

  // configuration registers
  logic [brtu_pkg::GAIN_W-1:0]  gain_q;
  logic [brtu_pkg::SHIFT_W-1:0] shift_q;

  logic               tgt_busy;
  logic               ramp_busy;
  brtu_pkg::tgt_req_t tgt_req;
  logic               accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= brtu_pkg::GAIN_RESET;
      shift_q <= brtu_pkg::SHIFT_RESET;
    end else if (cfg_we_i) begin
      unique case (brtu_pkg::cfg_idx_e'(cfg_idx_i))
        brtu_pkg::CFG_DEVIATION_GAIN: gain_q  <= cfg_data_i[brtu_pkg::GAIN_W-1:0];
        brtu_pkg::CFG_AVERAGE_SHIFT:  shift_q <= cfg_data_i[brtu_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // one sample in flight at a time
  assign sample_i.ready = !tgt_busy && !ramp_busy;
  assign accept         = sample_i.valid && sample_i.ready;

  // baseline and target stage
  brtu_target u_target (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .sample_i (sample_i.noise_sample),
    .gain_i   (gain_q),
    .shift_i  (shift_q),
    .busy_o   (tgt_busy),
    .req_o    (tgt_req)
  );

  // ramp engine with output register
  brtu_ramp u_ramp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (tgt_req),
    .busy_o  (ramp_busy),
    .trace_o (trace_o)
  );

  // the two stages never hold a sample at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tgt_busy && ramp_busy))
    else $error("target stage and ramp engine busy together");

  // an accepted request blocks the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !sample_i.ready)
    else $error("sample channel ready right after a request");

  // a final point is never followed straight away by another final point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (trace_o.valid && trace_o.ready && trace_o.last_point)
      |=> !(trace_o.valid && trace_o.last_point))
    else $error("two final points in a row");

  // a target hand-over only reaches an idle ramp engine
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tgt_req.valid |-> !ramp_busy)
    else $error("target handed to a busy ramp engine");

endmodule

// ----- hdl/brtu_target.sv -----
// ----------------------------------------------------------------------------
// brtu_target: baseline tracking and target computation
// moving average update, then gain multiply and saturation
// ----------------------------------------------------------------------------
module brtu_target (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [brtu_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic [brtu_pkg::GAIN_W-1:0]    gain_i,
  input  logic [brtu_pkg::SHIFT_W-1:0]   shift_i,
  output logic                           busy_o,
  output brtu_pkg::tgt_req_t             req_o
);

  brtu_pkg::tgt_state_e state_q, state_d;

  logic [brtu_pkg::SAMPLE_W-1:0] sample_q;
  logic [brtu_pkg::BASE_W-1:0]   baseline_q;
  logic                          primed_q;
  logic                          first_q;
  logic signed [8:0]             dev_q;
  brtu_pkg::tgt_req_t            req_q;

  logic [brtu_pkg::BASE_W-1:0]   base_sel;
  logic [brtu_pkg::BASE_W-1:0]   x_val;
  logic signed [16:0]            diff;
  logic signed [16:0]            diff_sh;
  logic [brtu_pkg::BASE_W-1:0]   avg_new;
  logic signed [8:0]             dev_new;
  logic signed [16:0]            prod;
  logic signed [17:0]            biased;
  logic [brtu_pkg::SAMPLE_W-1:0] tgt_sat;

  // baseline update
  always_comb begin
    x_val    = {sample_q, 8'h00};
    base_sel = primed_q ? baseline_q : x_val;
    diff     = $signed({1'b0, x_val}) - $signed({1'b0, base_sel});
    diff_sh  = diff >>> shift_i;
    avg_new  = base_sel + diff_sh[brtu_pkg::BASE_W-1:0];
    dev_new  = $signed({1'b0, sample_q}) - $signed({1'b0, avg_new[15:8]});
  end

  // gain and saturation
  always_comb begin
    prod   = dev_q * $signed({1'b0, gain_i});
    biased = $signed({prod[16], prod}) + $signed({10'd0, brtu_pkg::CENTRE});
    priority if (biased < 0) begin
      tgt_sat = '0;
    end else if (biased > $signed({10'd0, brtu_pkg::SAT_MAX})) begin
      tgt_sat = brtu_pkg::SAT_MAX;
    end else begin
      tgt_sat = biased[brtu_pkg::SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      brtu_pkg::TGT_IDLE: if (start_i) state_d = brtu_pkg::TGT_BASE;
      brtu_pkg::TGT_BASE: state_d = brtu_pkg::TGT_GAIN;
      brtu_pkg::TGT_GAIN: state_d = brtu_pkg::TGT_IDLE;
      default:            state_d = brtu_pkg::TGT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= brtu_pkg::TGT_IDLE;
      baseline_q <= '0;
      primed_q   <= 1'b0;
      req_q      <= '0;
    end else begin
      state_q     <= state_d;
      req_q.valid <= (state_q == brtu_pkg::TGT_GAIN);
      if (state_q == brtu_pkg::TGT_BASE) begin
        baseline_q <= avg_new;
        primed_q   <= 1'b1;
      end
      if (state_q == brtu_pkg::TGT_GAIN) begin
        req_q.first  <= first_q;
        req_q.target <= tgt_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == brtu_pkg::TGT_IDLE && start_i) begin
      sample_q <= sample_i;
    end
    if (state_q == brtu_pkg::TGT_BASE) begin
      dev_q   <= dev_new;
      first_q <= !primed_q;
    end
  end

  assign busy_o = (state_q != brtu_pkg::TGT_IDLE) || req_q.valid;
  assign req_o  = req_q;

endmodule

// ----- hdl/brtu_ramp.sv -----
// ----------------------------------------------------------------------------
// brtu_ramp: linear ramp generator
// one shared compare/subtract unit splits the step, then accumulates it
// ----------------------------------------------------------------------------
module brtu_ramp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  brtu_pkg::tgt_req_t req_i,
  output logic               busy_o,
  brtu_out_if.source         trace_o
);

  localparam logic [7:0] DIVISOR = 8'(brtu_pkg::POINTS_PER_SAMPLE);
  localparam logic [brtu_pkg::CNT_W-1:0] LAST_CNT =
    brtu_pkg::CNT_W'(brtu_pkg::POINTS_PER_SAMPLE - 1);

  brtu_pkg::ramp_state_e state_q, state_d;

  logic [brtu_pkg::SAMPLE_W-1:0] prev_q;
  logic [brtu_pkg::SAMPLE_W-1:0] start_q;
  logic [brtu_pkg::SAMPLE_W-1:0] target_q;
  logic                          neg_q;
  logic [7:0]                    div_r_q;
  logic [7:0]                    quo_q;
  logic [brtu_pkg::REM_W-1:0]    acc_r_q;
  logic [7:0]                    acc_q_q;
  logic [brtu_pkg::CNT_W-1:0]    cnt_q;
  logic                          out_valid_q;
  logic [brtu_pkg::SAMPLE_W-1:0] out_value_q;
  logic                          out_last_q;

  logic [brtu_pkg::SAMPLE_W-1:0] start_sel;
  logic [7:0]                    unit_a;
  logic [7:0]                    unit_diff;
  logic                          unit_ge;
  logic [7:0]                    acc_r_sum;
  logic [7:0]                    acc_r_next;
  logic [7:0]                    acc_q_next;
  logic [brtu_pkg::SAMPLE_W-1:0] point;
  logic                          load;
  logic                          is_last;

  assign start_sel = req_i.first ? req_i.target : prev_q;

  // shared compare/subtract against the point count
  assign acc_r_sum = 8'(acc_r_q) + div_r_q;
  assign unit_a    = (state_q == brtu_pkg::RAMP_DIV) ? div_r_q : acc_r_sum;
  assign unit_ge   = (unit_a >= DIVISOR);
  assign unit_diff = unit_a - DIVISOR;

  assign acc_r_next = unit_ge ? unit_diff : unit_a;
  assign acc_q_next = acc_q_q + quo_q + 8'(unit_ge);
  assign point      = neg_q ? (start_q - acc_q_next) : (start_q + acc_q_next);

  assign load    = (state_q == brtu_pkg::RAMP_EMIT) && (!out_valid_q || trace_o.ready);
  assign is_last = (cnt_q == LAST_CNT);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      brtu_pkg::RAMP_IDLE: if (req_i.valid) state_d = brtu_pkg::RAMP_DIV;
      brtu_pkg::RAMP_DIV:  if (!unit_ge) state_d = brtu_pkg::RAMP_EMIT;
      brtu_pkg::RAMP_EMIT: if (load && is_last) state_d = brtu_pkg::RAMP_IDLE;
      default:             state_d = brtu_pkg::RAMP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brtu_pkg::RAMP_IDLE;
      prev_q      <= brtu_pkg::CENTRE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (trace_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (load && is_last) begin
        prev_q <= target_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      brtu_pkg::RAMP_IDLE: begin
        if (req_i.valid) begin
          start_q  <= start_sel;
          target_q <= req_i.target;
          neg_q    <= (req_i.target < start_sel);
          div_r_q  <= (req_i.target < start_sel) ? (start_sel - req_i.target)
                                                 : (req_i.target - start_sel);
          quo_q    <= '0;
          acc_r_q  <= '0;
          acc_q_q  <= '0;
          cnt_q    <= '0;
        end
      end
      brtu_pkg::RAMP_DIV: begin
        if (unit_ge) begin
          div_r_q <= unit_diff;
          quo_q   <= quo_q + 8'd1;
        end
      end
      brtu_pkg::RAMP_EMIT: begin
        if (load) begin
          acc_r_q     <= acc_r_next[brtu_pkg::REM_W-1:0];
          acc_q_q     <= acc_q_next;
          cnt_q       <= cnt_q + 1'b1;
          out_value_q <= point;
          out_last_q  <= is_last;
        end
      end
      default: ;
    endcase
  end

  assign busy_o              = (state_q != brtu_pkg::RAMP_IDLE);
  assign trace_o.valid       = out_valid_q;
  assign trace_o.trace_value = out_value_q;
  assign trace_o.last_point  = out_last_q;

endmodule
